// ===== rtl/core/dcpb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcpb_pkg;

    localparam int PALETTE_DEPTH = 32;
    localparam int IDX_W         = 5;
    localparam int CNT_W         = 6;
    localparam int CHAN_W        = 8;
    localparam int KEY_W         = 3 * CHAN_W;
    localparam int ACC_W         = 24;

    // Q16 luma weights (0.2126, 0.7152, 0.0722), summing to 65536
    localparam logic [15:0] W_RED     = 16'd13933;
    localparam logic [15:0] W_GREEN   = 16'd46871;
    localparam logic [15:0] W_BLUE    = 16'd4732;
    localparam logic [ACC_W-1:0] LUMA_HALF = ACC_W'(32768);

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(PALETTE_DEPTH);

    // register index decoded from paddr[2]
    localparam logic REG_GRAY_MODE = 1'b0;

    typedef struct packed {
        logic              start_image;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } dcpb_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              was_added;
        logic              was_found;
        logic [IDX_W-1:0]  entry_index;
        logic [CNT_W-1:0]  palette_count;
        logic              palette_full;
    } dcpb_out_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] index;
    } dcpb_match_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcpb_luma.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcpb_luma
    import dcpb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             pix_valid,
    input  wire dcpb_in_t         pix,
    input  wire logic             gray_mode,
    output logic                  key_valid,
    output logic                  key_start,
    output logic [KEY_W-1:0]      key
);

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_start_reg;
    logic                 s1_gray_reg;
    logic [KEY_W-1:0]     s1_rgb_reg;
    logic [ACC_W-1:0]     s1_pr_reg, s1_pg_reg, s1_pb_reg;

    logic                 s2_valid_reg, s2_valid_next;
    logic                 s2_start_reg;
    logic [KEY_W-1:0]     s2_key_reg, s2_key_next;

    logic [ACC_W-1:0]     luma_acc;
    logic [CHAN_W-1:0]    luma;

    assign s1_valid_next = advance ? pix_valid : s1_valid_reg;
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;

    // round half up, then take the integer part of the Q16 sum
    assign luma_acc = s1_pr_reg + s1_pg_reg + s1_pb_reg + LUMA_HALF;
    assign luma     = luma_acc[ACC_W-1:ACC_W-CHAN_W];

    assign s2_key_next = s1_gray_reg ? {luma, luma, luma} : s1_rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_start_reg <= pix.start_image;
            s1_gray_reg  <= gray_mode;
            s1_rgb_reg   <= {pix.red_in, pix.green_in, pix.blue_in};
            s1_pr_reg    <= ACC_W'(W_RED) * ACC_W'(pix.red_in);
            s1_pg_reg    <= ACC_W'(W_GREEN) * ACC_W'(pix.green_in);
            s1_pb_reg    <= ACC_W'(W_BLUE) * ACC_W'(pix.blue_in);
            s2_start_reg <= s1_start_reg;
            s2_key_reg   <= s2_key_next;
        end
    end

    assign key_valid = s2_valid_reg;
    assign key_start = s2_start_reg;
    assign key       = s2_key_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dcpb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcpb_cell
    import dcpb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [CNT_W-1:0] fill_count,
    input  wire logic             append,
    input  wire dcpb_match_t      match_in,
    output dcpb_match_t           match_out,
    output logic                  hit
);

    logic [KEY_W-1:0] entry_reg, entry_next;
    logic             occupied;
    logic             wr_en;

    // slots below the fill count hold live colors
    assign occupied = {1'b0, cell_index} < fill_count;
    assign hit      = occupied && (entry_reg == key);

    // the palette holds no duplicates, so OR-merging the index is exact
    assign match_out.hit   = match_in.hit | hit;
    assign match_out.index = match_in.index | (hit ? cell_index : '0);

    assign wr_en      = append && (fill_count[IDX_W-1:0] == cell_index);
    assign entry_next = wr_en ? key : entry_reg;

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/distinct_color_palette_builder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Distinct color palette builder. Each request carries one RGB pixel; the
// block returns one result per request, in order. With gray_mode set
// (APB register at address 0, bit 0) the pixel is first turned into rounded
// Q16 luma and that value goes to all three channels. The color is looked up
// in a palette of 32 slots held in a row of cells, one cell per slot: every
// cell compares its slot against the key and hands the running match on to
// its neighbor. A color that is absent is appended at the next free slot;
// once 32 colors are held, pixels are reported with palette_full set and are
// neither reported as found nor stored. start_image empties the palette before its
// own pixel is handled, so that pixel lands in slot 0. Throughput is one
// pixel per clock when m_ready keeps up; a request passes through two
// luma stages, then the cell row and result register, where the fill count
// updates in the same cycle so back-to-back pixels see each other.
// Backpressure on m_ready stalls the whole pipe.

module distinct_color_palette_builder_core
    import dcpb_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // pixel requests
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire dcpb_in_t     s_data,
    // results
    output logic              m_valid,
    input  wire logic         m_ready,
    output dcpb_out_t         m_data,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic gray_mode_reg, gray_mode_next;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // decode on the word address only
    assign gray_mode_next = (cfg_write && (paddr[2] == REG_GRAY_MODE)) ? pwdata[0]
                                                                      : gray_mode_reg;

    assign prdata = (paddr[2] == REG_GRAY_MODE) ? {31'd0, gray_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_mode_reg <= 1'b0;
        end else begin
            gray_mode_reg <= gray_mode_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together when the result slot
    // is empty or being drained.
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg, out_valid_next;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    // ------------------------------------------------------------------
    // Luma stages
    // ------------------------------------------------------------------
    logic             key_valid;
    logic             key_start;
    logic [KEY_W-1:0] key;

    dcpb_luma u_luma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .pix_valid (s_valid),
        .pix       (s_data),
        .gray_mode (gray_mode_reg),
        .key_valid (key_valid),
        .key_start (key_start),
        .key       (key)
    );

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   fill_count;
    logic               step;
    logic               was_full;
    logic               append;
    dcpb_match_t        chain [0:PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] cell_hit;

    assign step       = advance && key_valid;
    // start empties the palette ahead of its own pixel
    assign fill_count = key_start ? '0 : count_reg;
    assign was_full   = (fill_count >= COUNT_FULL);
    assign append     = step && !was_full && !chain[PALETTE_DEPTH].hit;

    assign chain[0] = '0;

    for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
        dcpb_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(i)),
            .key        (key),
            .fill_count (fill_count),
            .append     (append),
            .match_in   (chain[i]),
            .match_out  (chain[i+1]),
            .hit        (cell_hit[i])
        );
    end

    // ------------------------------------------------------------------
    // Fill count and result register
    // ------------------------------------------------------------------
    dcpb_out_t result_next;
    dcpb_out_t out_data_reg;

    always_comb begin
        count_next = count_reg;
        if (step) begin
            count_next = append ? fill_count + CNT_W'(1) : fill_count;
        end
    end

    always_comb begin
        result_next.red_out       = key[KEY_W-1 -: CHAN_W];
        result_next.green_out     = key[2*CHAN_W-1 -: CHAN_W];
        result_next.blue_out      = key[CHAN_W-1:0];
        result_next.was_added     = !was_full && !chain[PALETTE_DEPTH].hit;
        result_next.was_found     = !was_full && chain[PALETTE_DEPTH].hit;
        result_next.entry_index   = '0;
        if (!was_full) begin
            // report the matched slot, or the slot just written
            result_next.entry_index = chain[PALETTE_DEPTH].hit
                                      ? chain[PALETTE_DEPTH].index
                                      : fill_count[IDX_W-1:0];
        end
        result_next.palette_count = count_next;
        result_next.palette_full  = (count_next >= COUNT_FULL);
    end

    assign out_valid_next = advance ? key_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_FULL)
        else $error("palette count above depth");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_hit))
        else $error("color matched in more than one slot");

    a_add_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.was_added) |->
            (m_data.palette_count == ({1'b0, m_data.entry_index} + CNT_W'(1))))
        else $error("added slot does not match new count");

    a_add_or_find: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.was_added && m_data.was_found))
        else $error("result both added and found");

    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(count_reg))
        else $error("fill count changed without a pixel");

endmodule

`default_nettype wire
